// ----- rtl/core/tkda_pkg.sv -----
// tkda_pkg: shared types and constants of the three-key debounce block
// payload structs, opcodes, key codes, register indexes and defaults, lane control and status structs
// no dependencies
`default_nettype none

package tkda_pkg;

	typedef logic [1:0]  code_t;
	typedef logic [1:0]  opcode_t;
	typedef logic [31:0] ms_t;
	typedef logic [15:0] cfg_val_t;
	typedef logic [1:0]  reg_idx_t;

	localparam opcode_t OP_SCAN = 2'd0;
	localparam opcode_t OP_TAKE = 2'd1;
	localparam opcode_t OP_INIT = 2'd2;

	localparam code_t CODE_NONE = 2'd0;
	localparam code_t CODE_MODE = 2'd1;
	localparam code_t CODE_UP   = 2'd2;
	localparam code_t CODE_DOWN = 2'd3;

	localparam reg_idx_t REG_SCAN_INTERVAL = 2'd0;
	localparam reg_idx_t REG_DEBOUNCE      = 2'd1;
	localparam reg_idx_t REG_REPEAT        = 2'd2;

	localparam cfg_val_t SCAN_INTERVAL_RST = 16'd5;
	localparam cfg_val_t DEBOUNCE_RST      = 16'd12;
	localparam cfg_val_t REPEAT_RST        = 16'd18;

	typedef struct packed {
		opcode_t opcode;
		ms_t     now_ms;
		logic    mode_level;
		logic    up_level;
		logic    down_level;
	} in_item_t;

	typedef struct packed {
		code_t taken_code;
		code_t pending_code;
	} out_item_t;

	// merge stage to key lane
	typedef struct packed {
		logic scan;
		logic init;
		logic consume;
	} lane_ctl_t;

	// key lane to merge stage, levels as they stand after this scan
	typedef struct packed {
		logic stable;
		logic press;
	} lane_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/three_key_debounce_autorepeat.sv -----
// three_key_debounce_autorepeat: top level of the three-key debounce and auto-repeat block
// holds the configuration registers and the output skid stage
// depends on tkda_pkg, tkda_key_lane, tkda_merge
// usage
//   in_valid/in_ready carry one transaction per input item: opcode (scan, take,
//   init), the millisecond time and the raw mode, up and down levels
//   out_valid/out_ready carry exactly one result transaction per input item:
//   the code handed out by a take and the pending code after the item
//   cfg_we/cfg_index/cfg_data write scan interval (0), debounce time (1) and
//   repeat period (2); other indexes are ignored; write only while idle
// timing
//   one item per cycle, sustained; the result shows on out_valid the cycle
//   after the input transaction, set by the single state update of the three
//   key lanes and the merge stage in one clock
// reset
//   arst_n clears all key state, the pending slot, scan and repeat times and
//   loads the register defaults 5, 12 and 18 ms
// stalls
//   a stalled result sits in the output register; one more item still goes into the skid
//   stage, then in_ready drops until the cycle after the stalled result is taken
`default_nettype none

module three_key_debounce_autorepeat (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire tkda_pkg::in_item_t  in_item,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output tkda_pkg::out_item_t      out_item,
	input  wire logic                cfg_we,
	input  wire tkda_pkg::reg_idx_t  cfg_index,
	input  wire tkda_pkg::cfg_val_t  cfg_data
);
	import tkda_pkg::*;

	// configuration registers
	cfg_val_t scan_int_q;
	cfg_val_t debounce_q;
	cfg_val_t repeat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_int_q <= SCAN_INTERVAL_RST;
			debounce_q <= DEBOUNCE_RST;
			repeat_q   <= REPEAT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCAN_INTERVAL: scan_int_q <= cfg_data;
				REG_DEBOUNCE:      debounce_q <= cfg_data;
				REG_REPEAT:        repeat_q   <= cfg_data;
				default:           ;
			endcase
		end
	end

	// output stage: main register plus one skid entry
	logic      out_valid_q;
	out_item_t out_q;
	logic      skid_valid_q;
	out_item_t skid_q;
	logic      accept;

	assign in_ready  = !skid_valid_q;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// lane links
	lane_ctl_t mode_ctl;
	lane_ctl_t up_ctl;
	lane_ctl_t down_ctl;
	lane_sts_t mode_sts;
	lane_sts_t up_sts;
	lane_sts_t down_sts;
	out_item_t result;

	// one debounce lane per key, all three work on the same transaction
	tkda_key_lane u_mode_lane (
		.clk         (clk),
		.arst_n      (arst_n),
		.level       (in_item.mode_level),
		.now_ms      (in_item.now_ms),
		.debounce_ms (debounce_q),
		.ctl         (mode_ctl),
		.sts         (mode_sts)
	);

	tkda_key_lane u_up_lane (
		.clk         (clk),
		.arst_n      (arst_n),
		.level       (in_item.up_level),
		.now_ms      (in_item.now_ms),
		.debounce_ms (debounce_q),
		.ctl         (up_ctl),
		.sts         (up_sts)
	);

	tkda_key_lane u_down_lane (
		.clk         (clk),
		.arst_n      (arst_n),
		.level       (in_item.down_level),
		.now_ms      (in_item.now_ms),
		.debounce_ms (debounce_q),
		.ctl         (down_ctl),
		.sts         (down_sts)
	);

	// merge: press priority, auto-repeat, pending slot, scan pacing
	tkda_merge u_merge (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.item             (in_item),
		.scan_interval_ms (scan_int_q),
		.repeat_ms        (repeat_q),
		.mode_sts         (mode_sts),
		.up_sts           (up_sts),
		.down_sts         (down_sts),
		.mode_ctl         (mode_ctl),
		.up_ctl           (up_ctl),
		.down_ctl         (down_ctl),
		.result           (result)
	);

	// control of the output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			// main register free this cycle: skid drains first
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload of the output stage, no reset
	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= result;
			end
		end else if (accept) begin
			skid_q <= result;
		end
	end

	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without a result in the output register");

	a_skid_not_lost: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |=> out_valid_q)
		else $error("skid entry dropped");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted transaction produced no result");

endmodule

`default_nettype wire

// ----- rtl/core/tkda_key_lane.sv -----
// tkda_key_lane: debounce lane for one key, holds raw, stable, press and change time
// depends on tkda_pkg
`default_nettype none

module tkda_key_lane (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               level,
	input  wire tkda_pkg::ms_t      now_ms,
	input  wire tkda_pkg::cfg_val_t debounce_ms,
	input  wire tkda_pkg::lane_ctl_t ctl,
	output tkda_pkg::lane_sts_t     sts
);
	import tkda_pkg::*;

	logic raw_q;
	logic stable_q;
	logic press_q;
	ms_t  change_q;

	logic raw_n;
	ms_t  change_n;
	logic settle;
	logic stable_n;
	logic press_n;

	always_comb begin
		raw_n    = level;
		change_n = (level != raw_q) ? now_ms : change_q;
		// settled long enough and different from the stable level
		settle   = ((now_ms - change_n) >= {16'd0, debounce_ms}) && (stable_q != raw_n);
		stable_n = settle ? raw_n : stable_q;
		press_n  = press_q | (settle & raw_n);
	end

	assign sts.stable = stable_n;
	assign sts.press  = press_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q    <= 1'b0;
			stable_q <= 1'b0;
			press_q  <= 1'b0;
			change_q <= '0;
		end else if (ctl.init) begin
			raw_q    <= level;
			stable_q <= level;
			press_q  <= 1'b0;
			change_q <= '0;
		end else if (ctl.scan) begin
			raw_q    <= raw_n;
			stable_q <= stable_n;
			press_q  <= press_n & ~ctl.consume;
			change_q <= change_n;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/tkda_merge.sv -----
// tkda_merge: combines the three key lanes, runs scan pacing, auto-repeat and the pending slot
// depends on tkda_pkg
`default_nettype none

module tkda_merge (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire tkda_pkg::in_item_t  item,
	input  wire tkda_pkg::cfg_val_t  scan_interval_ms,
	input  wire tkda_pkg::cfg_val_t  repeat_ms,
	input  wire tkda_pkg::lane_sts_t mode_sts,
	input  wire tkda_pkg::lane_sts_t up_sts,
	input  wire tkda_pkg::lane_sts_t down_sts,
	output tkda_pkg::lane_ctl_t      mode_ctl,
	output tkda_pkg::lane_ctl_t      up_ctl,
	output tkda_pkg::lane_ctl_t      down_ctl,
	output tkda_pkg::out_item_t      result
);
	import tkda_pkg::*;

	code_t held_q;
	ms_t   last_scan_q;
	ms_t   last_rep_q;

	logic  scan_go;
	logic  init_go;
	logic  take_go;
	logic  up_fire;
	logic  down_fire;
	ms_t   rep_base;
	logic  rep_due;
	code_t held_n;
	code_t taken;

	always_comb begin
		scan_go   = accept && (item.opcode == OP_SCAN) &&
		            ((item.now_ms - last_scan_q) >= {16'd0, scan_interval_ms});
		init_go   = accept && (item.opcode == OP_INIT);
		take_go   = accept && (item.opcode == OP_TAKE);
		up_fire   = up_sts.press && !down_sts.stable;
		// down press only looked at when the up branch stays quiet
		down_fire = !up_fire && down_sts.press && !up_sts.stable;
		rep_base  = (up_fire || down_fire) ? item.now_ms : last_rep_q;
		rep_due   = (item.now_ms - rep_base) >= {16'd0, repeat_ms};

		held_n = held_q;
		taken  = CODE_NONE;
		if (take_go) begin
			taken  = held_q;
			held_n = CODE_NONE;
		end else if (scan_go) begin
			if ((held_n == CODE_NONE) && mode_sts.press) begin
				held_n = CODE_MODE;
			end
			if (held_n == CODE_NONE) begin
				if (up_fire) begin
					held_n = CODE_UP;
				end else if (down_fire) begin
					held_n = CODE_DOWN;
				end
			end
			if ((held_n == CODE_NONE) && rep_due) begin
				if (up_sts.stable && !down_sts.stable) begin
					held_n = CODE_UP;
				end else if (down_sts.stable && !up_sts.stable) begin
					held_n = CODE_DOWN;
				end
			end
		end

		mode_ctl = '{scan: scan_go, init: init_go, consume: 1'b1};
		up_ctl   = '{scan: scan_go, init: init_go, consume: 1'b1};
		down_ctl = '{scan: scan_go, init: init_go, consume: !up_fire};

		result.taken_code   = taken;
		result.pending_code = held_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= CODE_NONE;
			last_scan_q <= '0;
			last_rep_q  <= '0;
		end else begin
			if (accept) begin
				held_q <= held_n;
			end
			if (scan_go) begin
				last_scan_q <= item.now_ms;
				if (rep_due || up_fire || down_fire) begin
					last_rep_q <= item.now_ms;
				end
			end
		end
	end

	a_take_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take_go |=> (held_q == CODE_NONE))
		else $error("pending slot not cleared by take");

	a_slot_keeps_first: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q != CODE_NONE) && !take_go |=> (held_q == $past(held_q)))
		else $error("pending code overwritten");

	a_up_press_queues: assert property (@(posedge clk) disable iff (!arst_n)
		scan_go && up_fire && !mode_sts.press && (held_q == CODE_NONE)
		|=> (held_q == CODE_UP))
		else $error("up press not queued");

endmodule

`default_nettype wire
